FILE: src/dodrd_pkg.sv
package dodrd_pkg;

    localparam int WORD_W      = 64;
    localparam int CNT_OUT_W   = 11;
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = 88;

    localparam int STATUS_LSB  = WORD_W;
    localparam int SKIP_LSB    = STATUS_LSB + STATUS_W;
    localparam int ADD_LSB     = SKIP_LSB + CNT_OUT_W;

    localparam logic REG_LOWER_BOUND = 1'b0;
    localparam logic REG_UPPER_BOUND = 1'b1;

    typedef enum logic [1:0] {
        ST_KEPT    = 2'd0,
        ST_SKIP    = 2'd1,
        ST_STOP    = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DELTA = 2'd1,
        KIND_DOD   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [WORD_W-1:0] operand;
        kind_t             kind;
        logic              first;
        logic              last;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t item;
    } q_wr_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_rd_t;

endpackage

FILE: src/dodrd_front.sv
module dodrd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dodrd_pkg::WORD_W-1:0] s_tdata,   // code_word
    input  logic [0:0]                   s_tuser,   // block_start
    input  logic                         s_tlast,   // block_end
    input  logic                         q_full,
    output dodrd_pkg::q_wr_t             wr
);
    import dodrd_pkg::*;

    kind_t             pos_reg;
    kind_t             pos_next;
    kind_t             pos_eff;
    logic [WORD_W-1:0] unzig;

    assign s_tready = !q_full;
    assign unzig    = (s_tdata >> 1) ^ {WORD_W{s_tdata[0]}};
    assign pos_eff  = s_tuser[0] ? KIND_START : pos_reg;

    always_comb
    begin
        wr.push       = s_tvalid && s_tready;
        wr.item.kind  = pos_eff;
        wr.item.first = s_tuser[0];
        wr.item.last  = s_tlast;
        wr.item.operand = (pos_eff == KIND_START) ? s_tdata : unzig;
        pos_next      = pos_reg;
        if (wr.push)
        begin
            if (s_tlast)
            begin
                pos_next = KIND_START;
            end
            else
            begin
                unique case (pos_eff)
                    KIND_START: pos_next = KIND_DELTA;
                    KIND_DELTA: pos_next = KIND_DOD;
                    default:    pos_next = KIND_DOD;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= KIND_START;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: src/dodrd_queue.sv
module dodrd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  dodrd_pkg::q_wr_t wr,
    output logic             full,
    output dodrd_pkg::q_rd_t rd,
    input  logic             pop
);
    import dodrd_pkg::*;

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign rd.valid = (count_reg != 2'd0);
    assign rd.item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr.push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, wr.push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem[wr_ptr_reg] <= wr.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/dodrd_back.sv
module dodrd_back #(
    parameter int MAX_BLOCK_WORDS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dodrd_pkg::q_rd_t                  rd,
    output logic                              pop,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [dodrd_pkg::WORD_W-1:0]      cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dodrd_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                              m_tlast
);
    import dodrd_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK_WORDS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK_WORDS);

    logic [WORD_W-1:0] lower_reg;
    logic [WORD_W-1:0] upper_reg;
    logic [WORD_W-1:0] value_reg;
    logic [WORD_W-1:0] value_next;
    logic [WORD_W-1:0] delta_reg;
    logic [WORD_W-1:0] delta_next;
    logic              stopped_reg;
    logic              stopped_next;
    logic [CNT_W-1:0]  skip_reg;
    logic [CNT_W-1:0]  skip_next;
    logic [CNT_W-1:0]  add_reg;
    logic [CNT_W-1:0]  add_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic [WORD_W-1:0] new_delta;
    logic [WORD_W-1:0] new_value;
    logic [WORD_W-1:0] shown;
    status_t           status;
    logic [CNT_W-1:0]  skip_res;
    logic [CNT_W-1:0]  add_res;

    assign cfg_ready = 1'b1;
    assign pop       = rd.valid && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;

    always_comb
    begin
        unique case (rd.item.kind)
            KIND_DELTA: new_delta = rd.item.operand;
            default:    new_delta = delta_reg + rd.item.operand;
        endcase
        unique case (rd.item.kind)
            KIND_START: new_value = rd.item.operand;
            default:    new_value = value_reg + new_delta;
        endcase

        value_next   = value_reg;
        delta_next   = delta_reg;
        stopped_next = rd.item.first ? 1'b0 : stopped_reg;
        skip_res     = rd.item.first ? '0 : skip_reg;
        add_res      = rd.item.first ? '0 : add_reg;
        shown        = '0;
        status       = ST_IGNORED;

        if (!stopped_next)
        begin
            value_next = new_value;
            delta_next = new_delta;
            if (new_value < lower_reg)
            begin
                status = ST_SKIP;
                if (skip_res < CNT_MAX)
                begin
                    skip_res = skip_res + 1'b1;
                end
            end
            else if (new_value > upper_reg)
            begin
                status       = ST_STOP;
                stopped_next = 1'b1;
            end
            else
            begin
                status = ST_KEPT;
                shown  = new_value;
                if (add_res < CNT_MAX)
                begin
                    add_res = add_res + 1'b1;
                end
            end
        end

        skip_next = skip_res;
        add_next  = add_res;
        // block end clears state after the result
        if (rd.item.last)
        begin
            stopped_next = 1'b0;
            skip_next    = '0;
            add_next     = '0;
        end

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg     <= '0;
            upper_reg     <= '1;
            value_reg     <= '0;
            delta_reg     <= '0;
            stopped_reg   <= 1'b0;
            skip_reg      <= '0;
            add_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_LOWER_BOUND)
                begin
                    lower_reg <= cfg_data;
                end
                else if (cfg_index == REG_UPPER_BOUND)
                begin
                    upper_reg <= cfg_data;
                end
            end
            if (pop)
            begin
                value_reg   <= value_next;
                delta_reg   <= delta_next;
                stopped_reg <= stopped_next;
                skip_reg    <= skip_next;
                add_reg     <= add_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= {CNT_OUT_W'(add_res), CNT_OUT_W'(skip_res), status, shown};
            out_last_reg <= rd.item.last;
        end
    end

endmodule

FILE: src/delta_of_delta_range_decoder_core.sv
// an accepted word goes into the queue; the back end then registers its result for m_tvalid
// throughput: one word per cycle while m_tready stays high, limited by the back-end update of the running value
//   (zigzag-decoded operand, two chained 64-bit adds and the bound compares)
// a two-word queue between front and back and a registered output absorb output stalls
//   until the queue fills, then s_tready drops
// reset: asynchronous, clears block state and the queue, sets lower bound 0 and upper bound all ones
module delta_of_delta_range_decoder_core #(
    parameter int MAX_BLOCK_WORDS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dodrd_pkg::WORD_W-1:0]      s_tdata,   // code_word
    input  logic [0:0]                        s_tuser,   // block_start
    input  logic                              s_tlast,   // block_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // rebuilt_value, status, skipped_total, added_total
    output logic [dodrd_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                              m_tlast,   // final_result
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [dodrd_pkg::WORD_W-1:0]      cfg_data
);
    import dodrd_pkg::*;

    q_wr_t wr;
    q_rd_t rd;
    logic  q_full;
    logic  pop;

    dodrd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .wr       (wr)
    );

    dodrd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .full  (q_full),
        .rd    (rd),
        .pop   (pop)
    );

    dodrd_back #(
        .MAX_BLOCK_WORDS (MAX_BLOCK_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (rd),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: src/dodrd_checker.sv
module dodrd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [dodrd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                              m_tlast
);
    import dodrd_pkg::*;

    a_no_valid_in_reset: assert property (@(posedge clk) !rst_n && $past(!rst_n) |-> !m_tvalid)
        else $error("result word valid during reset");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_zero_when_not_kept: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[STATUS_LSB +: STATUS_W] != ST_KEPT)
        |-> (m_tdata[WORD_W-1:0] == '0))
        else $error("rebuilt value nonzero on a value that was not kept");

endmodule

bind delta_of_delta_range_decoder_core dodrd_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: verif/tb.sv
module tb;
    import dodrd_pkg::*;

    localparam int BLOCK_MAX = 1024;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_WORDS = 1027;
    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [WORD_W-1:0]    value;
        status_t              status;
        logic [CNT_OUT_W-1:0] skipped;
        logic [CNT_OUT_W-1:0] added;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              start;
        logic              last;
        logic              typed;
        result_t           want;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [WORD_W-1:0]      s_tdata = '0;
    logic [0:0]             s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = REG_LOWER_BOUND;
    logic [WORD_W-1:0]      cfg_data = '0;

    delta_of_delta_range_decoder_core #(
        .MAX_BLOCK_WORDS(BLOCK_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // decoder state as the block should hold it
    logic [WORD_W-1:0] lo_bound = '0;
    logic [WORD_W-1:0] hi_bound = '1;
    logic [WORD_W-1:0] run_value;
    logic [WORD_W-1:0] run_delta;
    kind_t             run_pos;
    logic              run_stopped;
    int                run_skipped;
    int                run_added;

    result_t pending_results[$];
    row_t    plan[$];
    result_t want_res;

    int   errors = 0;
    int   cycle_count = 0;
    int   words_seen = 0;
    int   words_paced = 0;
    int   hold_left = 0;
    logic idle_on = 1'b1;

    logic [WORD_W-1:0] next_lo;
    logic [WORD_W-1:0] next_hi;
    int                sent;
    int                blk_len;

    function automatic void open_block();
        run_value = '0;
        run_delta = '0;
        run_pos = KIND_START;
        run_stopped = 1'b0;
        run_skipped = 0;
        run_added = 0;
    endfunction

    function automatic result_t decode_word(input logic [WORD_W-1:0] w, input logic start,
                                            input logic last);
        result_t r;
        logic [WORD_W-1:0] step;
        r = '0;
        if (start)
            open_block();
        // zigzag back to two's complement
        step = (w >> 1) ^ {WORD_W{w[0]}};
        if (run_stopped)
            r.status = ST_IGNORED;
        else
        begin
            case (run_pos)
                KIND_START:
                begin
                    run_value = w;
                    run_pos = KIND_DELTA;
                end
                KIND_DELTA:
                begin
                    run_delta = step;
                    run_value = run_value + step;
                    run_pos = KIND_DOD;
                end
                default:
                begin
                    run_delta = run_delta + step;
                    run_value = run_value + run_delta;
                end
            endcase
            if (run_value < lo_bound)
            begin
                r.status = ST_SKIP;
                if (run_skipped < BLOCK_MAX)
                    run_skipped++;
            end
            else if (run_value > hi_bound)
            begin
                r.status = ST_STOP;
                run_stopped = 1'b1;
            end
            else
            begin
                r.status = ST_KEPT;
                if (run_added < BLOCK_MAX)
                    run_added++;
                r.value = run_value;
            end
        end
        r.skipped = run_skipped[CNT_OUT_W-1:0];
        r.added = run_added[CNT_OUT_W-1:0];
        r.last = last;
        if (last)
            open_block();
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic check_field(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word %h with none pending", $time, m_tdata);
                errors++;
            end
            else
            begin
                want_res = pending_results.pop_front();
                check_field("rebuilt_value", want_res.value, m_tdata[WORD_W-1:0]);
                check_field("status", want_res.status, m_tdata[SKIP_LSB-1:STATUS_LSB]);
                check_field("skipped_total", want_res.skipped, m_tdata[ADD_LSB-1:SKIP_LSB]);
                check_field("added_total", want_res.added,
                            m_tdata[ADD_LSB+CNT_OUT_W-1:ADD_LSB]);
                check_field("final_result", want_res.last, m_tlast);
            end
            words_seen++;
        end
    end

    // receiver stall drawn once per result word
    always @(negedge clk)
    begin
        if (words_seen != words_paced)
        begin
            words_paced = words_seen;
            hold_left = idle_on ? $urandom_range(0, 13) : 0;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_word(input logic [WORD_W-1:0] w, input logic start, input logic last,
                             input logic typed, input result_t want);
        int gap;
        result_t predicted;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tuser <= start;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = decode_word(w, start, last);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [WORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_LOWER_BOUND)
            lo_bound = val;
        else
            hi_bound = val;
        @(negedge clk);
    endtask

    task automatic set_bounds(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        wait_drained();
        write_reg(REG_LOWER_BOUND, lo);
        write_reg(REG_UPPER_BOUND, hi);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic [WORD_W-1:0] w, input logic start, input logic last,
                           input logic typed, input logic [WORD_W-1:0] value,
                           input status_t status, input int skipped, input int added);
        row_t r;
        r.word = w;
        r.start = start;
        r.last = last;
        r.typed = typed;
        r.want.value = value;
        r.want.status = status;
        r.want.skipped = skipped[CNT_OUT_W-1:0];
        r.want.added = added[CNT_OUT_W-1:0];
        r.want.last = last;
        plan.insert(plan.size(), r);
    endtask

    task automatic run_plan();
        foreach (plan[i])
            send_word(plan[i].word, plan[i].start, plan[i].last, plan[i].typed, plan[i].want);
        plan.delete();
    endtask

    task automatic long_block(input logic [WORD_W-1:0] first_word);
        for (int k = 0; k < LONG_WORDS; k++)
            send_word((k == 0) ? first_word : '0, k == 0, k == LONG_WORDS - 1, 1'b0, '0);
    endtask

    task automatic send_block(input int len);
        logic [WORD_W-1:0] w;
        logic st;
        logic en;
        for (int k = 0; k < len; k++)
        begin
            if (k == 0)
            begin
                case ($urandom_range(0, 6))
                    0: w = lo_bound - $urandom_range(0, 64);
                    1: w = lo_bound + $urandom_range(0, 64);
                    2: w = hi_bound - $urandom_range(0, 64);
                    3: w = hi_bound + $urandom_range(0, 64);
                    4: w = rand64();
                    5: w = ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
                    default: w = lo_bound + $urandom_range(0, 4095);
                endcase
            end
            else if (k == 1)
            begin
                case ($urandom_range(0, 7))
                    0: w = rand64();
                    1: w = ALL_ONES - $urandom_range(0, 3);
                    default: w = $urandom_range(0, 80);
                endcase
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: w = rand64();
                    1: w = $urandom_range(0, 2000);
                    default: w = $urandom_range(0, 6);
                endcase
            end
            st = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 49) == 0);
            en = (k == len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 79) == 0);
            send_word(w, st, en, 1'b0, '0);
            if ($urandom_range(0, 299) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        open_block();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset bounds: wrap, zigzag extremes, end without start, start mid-block
        add_row(64'd0, 1'b1, 1'b0, 1'b1, 64'd0, ST_KEPT, 0, 1);
        add_row(64'd1, 1'b0, 1'b0, 1'b1, ALL_ONES, ST_KEPT, 0, 2);
        add_row(64'd2, 1'b0, 1'b0, 1'b0, '0, ST_KEPT, 0, 0);
        add_row(ALL_ONES, 1'b0, 1'b0, 1'b0, '0, ST_KEPT, 0, 0);
        add_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b1, 1'b0, '0, ST_KEPT, 0, 0);
        add_row(ALL_ONES, 1'b0, 1'b0, 1'b1, ALL_ONES, ST_KEPT, 0, 1);
        add_row(64'd5, 1'b1, 1'b0, 1'b1, 64'd5, ST_KEPT, 0, 1);
        add_row(64'd0, 1'b0, 1'b1, 1'b1, 64'd5, ST_KEPT, 0, 2);
        add_row(64'd123, 1'b1, 1'b1, 1'b1, 64'd123, ST_KEPT, 0, 1);
        add_row(64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0, '0, ST_KEPT, 0, 0);
        add_row(64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, '0, ST_KEPT, 0, 0);
        add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1, 1'b0, '0, ST_KEPT, 0, 0);
        run_plan();

        // narrow window: skip, keep at edges, stop, ignored words after stop
        set_bounds(64'd100, 64'd200);
        add_row(64'd50, 1'b1, 1'b0, 1'b1, 64'd0, ST_SKIP, 1, 0);
        add_row(64'd200, 1'b0, 1'b0, 1'b0, '0, ST_KEPT, 0, 0);
        add_row(64'd0, 1'b0, 1'b0, 1'b0, '0, ST_KEPT, 0, 0);
        add_row(64'd7, 1'b0, 1'b0, 1'b0, '0, ST_KEPT, 0, 0);
        add_row(64'd9, 1'b0, 1'b1, 1'b0, '0, ST_KEPT, 0, 0);
        add_row(64'd300, 1'b0, 1'b0, 1'b1, 64'd0, ST_STOP, 0, 0);
        add_row(64'd1, 1'b1, 1'b0, 1'b1, 64'd0, ST_SKIP, 1, 0);
        add_row(ALL_ONES, 1'b0, 1'b1, 1'b0, '0, ST_KEPT, 0, 0);
        add_row(64'd100, 1'b1, 1'b0, 1'b1, 64'd100, ST_KEPT, 0, 1);
        add_row(64'd200, 1'b0, 1'b1, 1'b0, '0, ST_KEPT, 0, 0);
        add_row(64'd201, 1'b1, 1'b1, 1'b1, 64'd0, ST_STOP, 0, 0);
        run_plan();

        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph)
                0:
                begin
                    next_lo = '0;
                    next_hi = ALL_ONES;
                end
                1:
                begin
                    next_lo = ALL_ONES;
                    next_hi = ALL_ONES;
                end
                2:
                begin
                    next_lo = '0;
                    next_hi = '0;
                end
                3:
                begin
                    next_lo = rand64();
                    next_hi = next_lo - $urandom_range(1, 500);
                end
                default:
                begin
                    next_lo = rand64();
                    next_hi = next_lo + $urandom_range(0, 3000);
                end
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            set_bounds(next_lo, next_hi);
            // saturating count: every word of a long block kept
            if (ph == 0)
                long_block(rand64());
            sent = 0;
            while (sent < 46)
            begin
                if ($urandom_range(0, 7) == 0)
                    blk_len = $urandom_range(13, 40);
                else
                    blk_len = $urandom_range(1, 12);
                send_block(blk_len);
                sent = sent + blk_len;
            end
        end

        wait_drained();
        repeat (4) @(negedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
src/dodrd_pkg.sv
src/dodrd_front.sv
src/dodrd_queue.sv
src/dodrd_back.sv
src/delta_of_delta_range_decoder_core.sv
src/dodrd_checker.sv
verif/tb.sv
